// ===== sv/etl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_pkg
// shared codes and types of the expression token lexer
// ----------------------------------------------------------------------------
package etl_pkg;

    // lexer modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_INT    = 3'd2;
    localparam logic [2:0] MODE_FRAC   = 3'd3;
    localparam logic [2:0] MODE_STRING = 3'd4;
    localparam logic [2:0] MODE_HALTED = 3'd5;

    // token kinds
    localparam logic [3:0] KIND_LPAR     = 4'd0;
    localparam logic [3:0] KIND_RPAR     = 4'd1;
    localparam logic [3:0] KIND_QUESTION = 4'd2;
    localparam logic [3:0] KIND_IDENT    = 4'd3;
    localparam logic [3:0] KIND_INT      = 4'd4;
    localparam logic [3:0] KIND_FLOAT    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd7;
    localparam logic [3:0] KIND_EOF      = 4'd8;

    // event kinds
    localparam logic EV_BYTE = 1'b0;
    localparam logic EV_DONE = 1'b1;

    // characters with a meaning of their own
    localparam logic [7:0] CH_LPAR     = 8'h28;
    localparam logic [7:0] CH_RPAR     = 8'h29;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_USCORE   = 8'h5F;
    localparam logic [7:0] CH_APOS     = 8'h27;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;

    typedef struct packed {
        logic       last;
        logic       event_kind;
        logic [7:0] value_byte;
        logic [3:0] token_kind;
        logic [7:0] token_length;
    } etl_result_t;

    typedef struct packed {
        logic        r0_valid;
        logic        r1_valid;
        etl_result_t r0;
        etl_result_t r1;
        logic [2:0]  mode_next;
        logic [7:0]  count_next;
    } etl_step_t;

endpackage

// ===== sv/etl_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_step
// one lexer step: classifies a character against the current mode and
// gives up to two results plus the next mode and length count
// ----------------------------------------------------------------------------
module etl_step #(
    parameter logic [7:0] LEN_CAP = 8'd255
) (
    input  logic [2:0]         mode,
    input  logic [7:0]         count,
    input  logic [7:0]         char_code,
    input  logic               end_of_text,
    output etl_pkg::etl_step_t step
);
    import etl_pkg::*;

    typedef struct packed {
        logic        hit;
        etl_result_t res;
        logic [2:0]  mode_next;
        logic [7:0]  count_next;
    } idle_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'd65:8'd90], [8'd97:8'd122]};
    endfunction

    function automatic etl_result_t mk_byte(input logic [7:0] c);
        etl_result_t r;
        r = '0;
        r.event_kind = EV_BYTE;
        r.value_byte = c;
        return r;
    endfunction

    function automatic etl_result_t mk_done(input logic [3:0] k, input logic [7:0] len);
        etl_result_t r;
        r = '0;
        r.event_kind   = EV_DONE;
        r.token_kind   = k;
        r.token_length = len;
        return r;
    endfunction

    // handling of a character between tokens, length count starts at zero
    function automatic idle_t do_idle(input logic [7:0] c, input logic eot);
        idle_t o;
        o = '0;
        o.mode_next = MODE_IDLE;
        if (eot) begin
            o.hit = 1'b1;
            o.res = mk_done(KIND_EOF, 8'd0);
            o.mode_next = MODE_HALTED;
        end else if (is_space(c)) begin
            o.hit = 1'b0;
        end else if (c == CH_LPAR) begin
            o.hit = 1'b1;
            o.res = mk_done(KIND_LPAR, 8'd0);
        end else if (c == CH_RPAR) begin
            o.hit = 1'b1;
            o.res = mk_done(KIND_RPAR, 8'd0);
        end else if (c == CH_QUESTION) begin
            o.hit = 1'b1;
            o.res = mk_done(KIND_QUESTION, 8'd0);
        end else if (is_alpha(c)) begin
            o.hit = 1'b1;
            o.res = mk_byte(c);
            o.mode_next = MODE_IDENT;
            o.count_next = 8'd1;
        end else if (is_digit(c)) begin
            o.hit = 1'b1;
            o.res = mk_byte(c);
            o.mode_next = MODE_INT;
            o.count_next = 8'd1;
        end else if (c == CH_DQUOTE) begin
            o.hit = 1'b0;
            o.mode_next = MODE_STRING;
        end else begin
            o.hit = 1'b1;
            o.res = mk_done(KIND_UNKNOWN, 8'd0);
            o.mode_next = MODE_HALTED;
        end
        return o;
    endfunction

    idle_t       idle_res;
    logic [7:0]  count_inc;
    logic        tail_ok;
    logic        close_tok;
    logic [3:0]  close_kind;

    assign idle_res  = do_idle(char_code, end_of_text);
    assign count_inc = (count < LEN_CAP) ? count + 8'd1 : count;
    assign tail_ok   = is_alpha(char_code) || is_digit(char_code)
                       || char_code == CH_USCORE || char_code == CH_APOS;

    always_comb begin
        step = '0;
        step.mode_next  = mode;
        step.count_next = count;
        close_tok  = 1'b0;
        close_kind = KIND_IDENT;
        case (mode)
            MODE_IDLE: begin
                step.r0_valid   = idle_res.hit;
                step.r0         = idle_res.res;
                step.mode_next  = idle_res.mode_next;
                step.count_next = idle_res.count_next;
            end
            MODE_IDENT: begin
                if (!end_of_text && tail_ok) begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_byte(char_code);
                    step.count_next = count_inc;
                end else begin
                    close_tok  = 1'b1;
                    close_kind = KIND_IDENT;
                end
            end
            MODE_INT: begin
                if (!end_of_text && is_digit(char_code)) begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_byte(char_code);
                    step.count_next = count_inc;
                end else if (!end_of_text && char_code == CH_DOT) begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_byte(char_code);
                    step.count_next = count_inc;
                    step.mode_next  = MODE_FRAC;
                end else begin
                    close_tok  = 1'b1;
                    close_kind = KIND_INT;
                end
            end
            MODE_FRAC: begin
                if (!end_of_text && is_digit(char_code)) begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_byte(char_code);
                    step.count_next = count_inc;
                end else begin
                    close_tok  = 1'b1;
                    close_kind = KIND_FLOAT;
                end
            end
            MODE_STRING: begin
                if (end_of_text) begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_done(KIND_UNKNOWN, count);
                    step.count_next = 8'd0;
                    step.mode_next  = MODE_HALTED;
                end else if (char_code == CH_DQUOTE) begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_done(KIND_STRING, count);
                    step.count_next = 8'd0;
                    step.mode_next  = MODE_IDLE;
                end else begin
                    step.r0_valid   = 1'b1;
                    step.r0         = mk_byte(char_code);
                    step.count_next = count_inc;
                end
            end
            default: begin
                step.mode_next = MODE_HALTED;
            end
        endcase

        // token ended: completion first, then the ending char handled afresh
        if (close_tok) begin
            step.r0_valid   = 1'b1;
            step.r0         = mk_done(close_kind, count);
            step.r1_valid   = idle_res.hit;
            step.r1         = idle_res.res;
            step.mode_next  = idle_res.mode_next;
            step.count_next = idle_res.count_next;
        end

        if (step.r1_valid) begin
            step.r1.last = 1'b1;
        end else begin
            step.r0.last = 1'b1;
        end
    end

endmodule

// ===== sv/expression_token_lexer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_token_lexer_core
// streaming lexer for expression text, one character per transfer
// ----------------------------------------------------------------------------
// usage:
//   slave side: one character per transfer on s_tdata, s_tlast marks end of
//   text (character ignored then). master side: value byte events
//   (m_tuser low) and token completion events (m_tuser high, kind and
//   length in m_tdata); m_tlast flags the last result of an input transfer.
//   a character is held in the input register while the lexer step works on
//   it, and its first result is registered in the output register.
//   throughput: one character per cycle unless the output stalls, set by
//   the combinational step between the registers; a character that ends a
//   token and has a result of its own holds off the next until both are out.
//   whitespace and an opening quote produce no result.
//   reset: lexer idle between tokens, length count zero, all registers empty.
//   after end of text or an unknown character the lexer halts: transfers are
//   still taken but produce nothing until reset.
//   stall: when m_tready is low the output register holds, a step that has
//   a result waits and the input register holds its character; s_tready
//   then drops.
// ----------------------------------------------------------------------------
module expression_token_lexer_core #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] value_byte, [11:8] token_kind,
                                   // [19:12] token_length, [23:20] zero
    output logic        m_tuser,   // event_kind
    output logic        m_tlast    // last_of_run
);
    import etl_pkg::*;

    // length saturates at the smaller of the parameter and the field maximum
    localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN > 255) ? 8'd255 : 8'(MAX_TOKEN_LEN);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg,  in_char_next;
    logic        in_eot_reg,   in_eot_next;

    // lexer state
    logic [2:0]  mode_reg,  mode_next;
    logic [7:0]  count_reg, count_next;

    // output register and the held second result
    logic        out_valid_reg,  out_valid_next;
    etl_result_t out_reg,        out_next;
    logic        pend_valid_reg, pend_valid_next;
    etl_result_t pend_reg,       pend_next;

    etl_step_t   step;
    logic        out_free;
    logic        step_fire;

    etl_step #(
        .LEN_CAP (LEN_CAP)
    ) u_step (
        .mode        (mode_reg),
        .count       (count_reg),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .step        (step)
    );

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    // a step runs when no second result is waiting and its first result
    // has a place to go
    assign step_fire = in_valid_reg && !pend_valid_reg && (!step.r0_valid || out_free);

    assign s_tready = !in_valid_reg || step_fire;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_char_next    = in_char_reg;
        in_eot_next     = in_eot_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (pend_valid_reg && out_free) begin
            // second result of the previous character goes out first
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end else if (step_fire) begin
            mode_next  = step.mode_next;
            count_next = step.count_next;
            if (step.r0_valid) begin
                out_valid_next = 1'b1;
                out_next       = step.r0;
            end
            if (step.r1_valid) begin
                pend_valid_next = 1'b1;
                pend_next       = step.r1;
            end
        end

        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_char_next  = s_tdata;
            in_eot_next   = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mode_reg       <= MODE_IDLE;
            count_reg      <= 8'd0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_char_reg <= in_char_next;
        in_eot_reg  <= in_eot_next;
        out_reg     <= out_next;
        pend_reg    <= pend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.token_length, out_reg.token_kind, out_reg.value_byte};
    assign m_tuser  = out_reg.event_kind;
    assign m_tlast  = out_reg.last;

endmodule
